@@ rtl/chip8ie_pkg.sv @@
// ----------------------------------------------------------------------------
// chip8ie_pkg
// Shared opcode codes and the execute result record of the CHIP-8 executor.
// ----------------------------------------------------------------------------
package chip8ie_pkg;

   localparam int unsigned PC_W    = 12;
   localparam int unsigned INDEX_W = 16;
   localparam int unsigned VREG_W  = 8;
   localparam int unsigned VNUM_W  = 4;
   localparam int unsigned NUM_V   = 16;

   // Instruction classes (top nibble)
   localparam logic [3:0] CLS_SYS  = 4'h0;
   localparam logic [3:0] CLS_JP   = 4'h1;
   localparam logic [3:0] CLS_CALL = 4'h2;
   localparam logic [3:0] CLS_SE   = 4'h3;
   localparam logic [3:0] CLS_SNE  = 4'h4;
   localparam logic [3:0] CLS_SEV  = 4'h5;
   localparam logic [3:0] CLS_LD   = 4'h6;
   localparam logic [3:0] CLS_ADD  = 4'h7;
   localparam logic [3:0] CLS_ALU  = 4'h8;
   localparam logic [3:0] CLS_SNEV = 4'h9;
   localparam logic [3:0] CLS_LDI  = 4'hA;
   localparam logic [3:0] CLS_JPV0 = 4'hB;
   localparam logic [3:0] CLS_RND  = 4'hC;
   localparam logic [3:0] CLS_DRW  = 4'hD;
   localparam logic [3:0] CLS_KEY  = 4'hE;
   localparam logic [3:0] CLS_MISC = 4'hF;

   // 8XYN function codes
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // FXNN codes
   localparam logic [7:0] FX_GET_DT = 8'h07;
   localparam logic [7:0] FX_SET_DT = 8'h15;
   localparam logic [7:0] FX_SET_ST = 8'h18;
   localparam logic [7:0] FX_ADD_I  = 8'h1E;

   localparam logic [15:0] OP_CLS = 16'h00E0;

   localparam logic [VNUM_W-1:0] V0_NUM = 4'h0;
   localparam logic [VNUM_W-1:0] VF_NUM = 4'hF;

   typedef struct packed {
      logic [PC_W-1:0]    next_pc;
      logic [INDEX_W-1:0] index_value;
      logic               dest_valid;
      logic [VNUM_W-1:0]  dest_reg;
      logic [VREG_W-1:0]  dest_value;
      logic               flag_valid;
      logic               flag_value;
      logic               clear_screen;
      logic [7:0]         delay_value;
      logic [7:0]         sound_value;
      logic               status;
   } exec_result_type;

endpackage

@@ rtl/chip8ie_exec.sv @@
// ----------------------------------------------------------------------------
// chip8ie_exec
// Decode and execute of one instruction against the current register values.
// ----------------------------------------------------------------------------
module chip8ie_exec
   import chip8ie_pkg::*;
(
   input  logic [15:0]         instr_word,
   input  logic [7:0]          random_byte,
   input  logic [VREG_W-1:0]   vx,
   input  logic [VREG_W-1:0]   vy,
   input  logic [VREG_W-1:0]   v0,
   input  logic [PC_W-1:0]     pc,
   input  logic [INDEX_W-1:0]  index_cur,
   input  logic [7:0]          delay_cur,
   input  logic [7:0]          sound_cur,
   output exec_result_type     result
);

   logic [3:0]        cls;
   logic [3:0]        x_num;
   logic [3:0]        n_fn;
   logic [7:0]        nn;
   logic [PC_W-1:0]   nnn;
   logic [PC_W-1:0]   pc_plus2;
   logic [PC_W-1:0]   pc_plus4;
   logic [8:0]        sum_xy;
   logic [8:0]        diff_xy;
   logic [8:0]        diff_yx;
   logic              skip;
   logic              jump;
   logic [PC_W-1:0]   jump_target;

   assign cls      = instr_word[15:12];
   assign x_num    = instr_word[11:8];
   assign n_fn     = instr_word[3:0];
   assign nn       = instr_word[7:0];
   assign nnn      = instr_word[11:0];
   assign pc_plus2 = pc + PC_W'(2);
   assign pc_plus4 = pc + PC_W'(4);
   assign sum_xy   = {1'b0, vx} + {1'b0, vy};
   assign diff_xy  = {1'b0, vx} - {1'b0, vy};
   assign diff_yx  = {1'b0, vy} - {1'b0, vx};

   always_comb begin
      skip        = 1'b0;
      jump        = 1'b0;
      jump_target = nnn;
      result              = '0;
      result.index_value  = index_cur;
      result.delay_value  = delay_cur;
      result.sound_value  = sound_cur;

      case (cls)
         CLS_SYS: begin
            if (instr_word == OP_CLS) begin
               result.clear_screen = 1'b1;
            end else begin
               result.status = 1'b1;
            end
         end
         CLS_JP, CLS_CALL: begin
            jump = 1'b1;
         end
         CLS_SE: begin
            skip = (vx == nn);
         end
         CLS_SNE: begin
            skip = (vx != nn);
         end
         CLS_SEV: begin
            if (n_fn == 4'h0) begin
               skip = (vx == vy);
            end else begin
               result.status = 1'b1;
            end
         end
         CLS_LD: begin
            result.dest_valid = 1'b1;
            result.dest_value = nn;
         end
         CLS_ADD: begin
            result.dest_valid = 1'b1;
            result.dest_value = vx + nn;
         end
         CLS_ALU: begin
            result.dest_valid = 1'b1;
            case (n_fn)
               ALU_MOV: result.dest_value = vy;
               ALU_OR:  result.dest_value = vx | vy;
               ALU_AND: result.dest_value = vx & vy;
               ALU_XOR: result.dest_value = vx ^ vy;
               ALU_ADD: begin
                  result.dest_value = sum_xy[7:0];
                  result.flag_valid = 1'b1;
                  result.flag_value = sum_xy[8];
               end
               ALU_SUB: begin
                  result.dest_value = diff_xy[7:0];
                  result.flag_valid = 1'b1;
                  result.flag_value = ~diff_xy[8];
               end
               ALU_SHR: begin
                  result.dest_value = {1'b0, vy[7:1]};
                  result.flag_valid = 1'b1;
                  result.flag_value = vy[0];
               end
               ALU_SUBN: begin
                  result.dest_value = diff_yx[7:0];
                  result.flag_valid = 1'b1;
                  result.flag_value = ~diff_yx[8];
               end
               ALU_SHL: begin
                  result.dest_value = {vy[6:0], 1'b0};
                  result.flag_valid = 1'b1;
                  result.flag_value = vy[7];
               end
               default: begin
                  result.dest_valid = 1'b0;
                  result.status     = 1'b1;
               end
            endcase
         end
         CLS_SNEV: begin
            if (n_fn == 4'h0) begin
               skip = (vx != vy);
            end else begin
               result.status = 1'b1;
            end
         end
         CLS_LDI: begin
            result.index_value = {4'h0, nnn};
         end
         CLS_JPV0: begin
            jump        = 1'b1;
            jump_target = nnn + {4'h0, v0};
         end
         CLS_RND: begin
            result.dest_valid = 1'b1;
            result.dest_value = random_byte & nn;
         end
         CLS_MISC: begin
            case (nn)
               FX_GET_DT: begin
                  result.dest_valid = 1'b1;
                  result.dest_value = delay_cur;
               end
               FX_SET_DT: result.delay_value = vx;
               FX_SET_ST: result.sound_value = vx;
               FX_ADD_I:  result.index_value = index_cur + {8'h00, vx};
               default:   result.status = 1'b1;
            endcase
         end
         default: begin
            // drawing and key instructions are not handled
            result.status = 1'b1;
         end
      endcase

      if (result.dest_valid) begin
         result.dest_reg = x_num;
      end

      if (jump) begin
         result.next_pc = jump_target;
      end else if (skip) begin
         result.next_pc = pc_plus4;
      end else begin
         result.next_pc = pc_plus2;
      end
   end

endmodule

@@ rtl/chip8_instruction_execute.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 instruction executor with V register file, I, PC and timers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one fetched instruction word and a random byte per beat.
//   rsp_* carries one result beat per instruction: new PC, I, the V register
//   and VF writes, clear-screen request, timer contents and status.
//   Path: an accepted req beat reads VX and VY from the register file memory
//   into the input register; the instruction then executes and loads the
//   result register, which shows the rsp beat as valid.
//   Throughput: one instruction per cycle while rsp_ready is high. PC, I, timers and V registers are
//   updated when the instruction executes, so the next instruction sees them;
//   a V register written in the same cycle as the next read is forwarded.
//   Reset: PC loads PROGRAM_START, I, timers and all V registers read as zero
//   (V register valid bits clear together; no clearing pass).
//   Stall: when rsp_ready is low the result is held; one more instruction
//   waits in the input register and req_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module chip8_instruction_execute
   import chip8ie_pkg::*;
#(
   parameter int unsigned PROGRAM_START = 512
)
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  logic [15:0]  req_instr_word,
   input  logic [7:0]   req_random_byte,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [11:0]  rsp_next_pc,
   output logic [15:0]  rsp_index_value,
   output logic         rsp_dest_valid,
   output logic [3:0]   rsp_dest_reg,
   output logic [7:0]   rsp_dest_value,
   output logic         rsp_flag_valid,
   output logic         rsp_flag_value,
   output logic         rsp_clear_screen,
   output logic [7:0]   rsp_delay_value,
   output logic [7:0]   rsp_sound_value,
   output logic         rsp_status
);

   localparam logic [PC_W-1:0] PC_RESET = PC_W'(PROGRAM_START);

   // input stage
   logic               in_valid_ff, in_valid_in;
   logic [15:0]        instr_ff;
   logic [7:0]         rnd_ff;
   logic [VREG_W-1:0]  rd_x_ff, rd_y_ff;
   logic               vld_x_ff, vld_y_ff;
   logic               fwd_x_ff, fwd_y_ff;
   logic [VREG_W-1:0]  fwd_val_ff;

   // architectural state
   logic [VREG_W-1:0]  vreg_mem [NUM_V];
   logic [NUM_V-1:0]   vld_ff, vld_in;
   logic [VREG_W-1:0]  v0_ff, v0_in;
   logic [VREG_W-1:0]  vf_ff, vf_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [7:0]         delay_ff, delay_in;
   logic [7:0]         sound_ff, sound_in;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   exec_result_type    rsp_ff;
   exec_result_type    exec_res;

   logic               req_fire;
   logic               exec_fire;
   logic [VNUM_W-1:0]  req_x, req_y;
   logic [VNUM_W-1:0]  ex_x, ex_y;
   logic [VREG_W-1:0]  ex_vx, ex_vy;
   logic               mem_we;

   assign req_x     = req_instr_word[11:8];
   assign req_y     = req_instr_word[7:4];
   assign ex_x      = instr_ff[11:8];
   assign ex_y      = instr_ff[7:4];

   assign exec_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;

   // V0 and VF read from flops; VF is not stored in memory and takes the flag last
   assign mem_we = exec_fire && exec_res.dest_valid && (exec_res.dest_reg != VF_NUM);

   always_comb begin
      if (ex_x == V0_NUM) begin
         ex_vx = v0_ff;
      end else if (ex_x == VF_NUM) begin
         ex_vx = vf_ff;
      end else if (fwd_x_ff) begin
         ex_vx = fwd_val_ff;
      end else begin
         ex_vx = vld_x_ff ? rd_x_ff : '0;
      end

      if (ex_y == V0_NUM) begin
         ex_vy = v0_ff;
      end else if (ex_y == VF_NUM) begin
         ex_vy = vf_ff;
      end else if (fwd_y_ff) begin
         ex_vy = fwd_val_ff;
      end else begin
         ex_vy = vld_y_ff ? rd_y_ff : '0;
      end
   end

   chip8ie_exec u_exec (
      .instr_word  (instr_ff),
      .random_byte (rnd_ff),
      .vx          (ex_vx),
      .vy          (ex_vy),
      .v0          (v0_ff),
      .pc          (pc_ff),
      .index_cur   (index_ff),
      .delay_cur   (delay_ff),
      .sound_cur   (sound_ff),
      .result      (exec_res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      vld_in       = vld_ff;
      v0_in        = v0_ff;
      vf_in        = vf_ff;
      pc_in        = pc_ff;
      index_in     = index_ff;
      delay_in     = delay_ff;
      sound_in     = sound_ff;

      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (exec_fire) begin
         in_valid_in = 1'b0;
      end

      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (exec_fire) begin
         pc_in    = exec_res.next_pc;
         index_in = exec_res.index_value;
         delay_in = exec_res.delay_value;
         sound_in = exec_res.sound_value;
         if (mem_we) begin
            vld_in[exec_res.dest_reg] = 1'b1;
         end
         if (exec_res.dest_valid && exec_res.dest_reg == V0_NUM) begin
            v0_in = exec_res.dest_value;
         end
         if (exec_res.flag_valid) begin
            vf_in = {7'h00, exec_res.flag_value};
         end else if (exec_res.dest_valid && exec_res.dest_reg == VF_NUM) begin
            vf_in = exec_res.dest_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         v0_ff        <= '0;
         vf_ff        <= '0;
         pc_ff        <= PC_RESET;
         index_ff     <= '0;
         delay_ff     <= '0;
         sound_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
         v0_ff        <= v0_in;
         vf_ff        <= vf_in;
         pc_ff        <= pc_in;
         index_ff     <= index_in;
         delay_ff     <= delay_in;
         sound_ff     <= sound_in;
      end
   end

   // register file memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vreg_mem[exec_res.dest_reg] <= exec_res.dest_value;
      end
      if (req_fire) begin
         rd_x_ff <= vreg_mem[req_x];
         rd_y_ff <= vreg_mem[req_y];
      end
   end

   // input register; catch a write landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         instr_ff   <= req_instr_word;
         rnd_ff     <= req_random_byte;
         vld_x_ff   <= vld_ff[req_x];
         vld_y_ff   <= vld_ff[req_y];
         fwd_x_ff   <= mem_we && (exec_res.dest_reg == req_x);
         fwd_y_ff   <= mem_we && (exec_res.dest_reg == req_y);
         fwd_val_ff <= exec_res.dest_value;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= exec_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_ff.next_pc;
   assign rsp_index_value  = rsp_ff.index_value;
   assign rsp_dest_valid   = rsp_ff.dest_valid;
   assign rsp_dest_reg     = rsp_ff.dest_reg;
   assign rsp_dest_value   = rsp_ff.dest_value;
   assign rsp_flag_valid   = rsp_ff.flag_valid;
   assign rsp_flag_value   = rsp_ff.flag_value;
   assign rsp_clear_screen = rsp_ff.clear_screen;
   assign rsp_delay_value  = rsp_ff.delay_value;
   assign rsp_sound_value  = rsp_ff.sound_value;
   assign rsp_status       = rsp_ff.status;

endmodule

@@ rtl/chip8ie_checker.sv @@
// ----------------------------------------------------------------------------
// chip8ie_checker
// Port-level checks of the CHIP-8 executor, bound to the top level.
// ----------------------------------------------------------------------------
module chip8ie_checker
   import chip8ie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  logic [11:0]  rsp_next_pc,
   input  logic [15:0]  rsp_index_value,
   input  logic         rsp_dest_valid,
   input  logic [3:0]   rsp_dest_reg,
   input  logic [7:0]   rsp_dest_value,
   input  logic         rsp_flag_valid,
   input  logic         rsp_flag_value,
   input  logic         rsp_clear_screen,
   input  logic         rsp_status
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc)
         && $stable(rsp_index_value) && $stable(rsp_dest_value))
      else $error("stalled rsp beat changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an unhandled instruction writes nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_dest_valid && !rsp_flag_valid
         && !rsp_clear_screen)
      else $error("unhandled instruction reported a write");

   // flag writes only come from ALU ops, which always write a destination
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag_valid |-> rsp_dest_valid && !rsp_status)
      else $error("flag write without destination write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dest_valid |-> rsp_dest_reg == V0_NUM && rsp_dest_value == 8'h00
         && (rsp_flag_valid || !rsp_flag_value))
      else $error("destination fields not cleared");

endmodule

bind chip8_instruction_execute chip8ie_checker u_checker (.*);

@@ tb/sv/chip8_exec_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chip8_exec_checker
// Watches the req and rsp channels of the CHIP-8 executor, runs every accepted
// instruction against a shadow register state and compares each result beat,
// field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module chip8_exec_checker
   import chip8ie_pkg::*;
#(
   parameter int unsigned PROGRAM_START = 512
)
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   input  logic         req_ready,
   input  logic [15:0]  req_instr_word,
   input  logic [7:0]   req_random_byte,

   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  logic [11:0]  rsp_next_pc,
   input  logic [15:0]  rsp_index_value,
   input  logic         rsp_dest_valid,
   input  logic [3:0]   rsp_dest_reg,
   input  logic [7:0]   rsp_dest_value,
   input  logic         rsp_flag_valid,
   input  logic         rsp_flag_value,
   input  logic         rsp_clear_screen,
   input  logic [7:0]   rsp_delay_value,
   input  logic [7:0]   rsp_sound_value,
   input  logic         rsp_status,

   output int           fail_count,
   output int           pending_count,
   output int           checked_count,
   output int           unhandled_count,
   output int           skip_count,
   output int           flag_count
);

   logic [VREG_W-1:0]  vreg_file [NUM_V];
   logic [INDEX_W-1:0] index_shadow;
   logic [PC_W-1:0]    pc_shadow;
   logic [7:0]         delay_shadow;
   logic [7:0]         sound_shadow;

   exec_result_type expected_results [$];

   int mismatch_tally  = 0;
   int checked_tally   = 0;
   int unhandled_tally = 0;
   int skip_tally      = 0;
   int flag_tally      = 0;

   // Execute one instruction on the shadow state and build its result beat.
   task automatic execute_instr(input logic [15:0] word, input logic [7:0] rnd,
                                output exec_result_type res);
      logic [3:0]        cls, x, y, n;
      logic [7:0]        nn, vx, vy;
      logic [11:0]       nnn, pc;
      logic [8:0]        sum;
      logic              skip;
      res  = '0;
      cls  = word[15:12];
      x    = word[11:8];
      y    = word[7:4];
      n    = word[3:0];
      nn   = word[7:0];
      nnn  = word[11:0];
      vx   = vreg_file[x];
      vy   = vreg_file[y];
      pc   = pc_shadow + 12'd2;
      skip = 1'b0;
      case (cls)
         CLS_SYS: begin
            if (word == OP_CLS) res.clear_screen = 1'b1;
            else res.status = 1'b1;
         end
         CLS_JP, CLS_CALL: pc = nnn;
         CLS_SE:  skip = (vx == nn);
         CLS_SNE: skip = (vx != nn);
         CLS_SEV: begin
            if (n == 4'h0) skip = (vx == vy);
            else res.status = 1'b1;
         end
         CLS_LD: begin
            res.dest_valid = 1'b1;
            res.dest_value = nn;
         end
         CLS_ADD: begin
            res.dest_valid = 1'b1;
            res.dest_value = vx + nn;
         end
         CLS_ALU: begin
            res.dest_valid = 1'b1;
            case (n)
               ALU_MOV: res.dest_value = vy;
               ALU_OR:  res.dest_value = vx | vy;
               ALU_AND: res.dest_value = vx & vy;
               ALU_XOR: res.dest_value = vx ^ vy;
               ALU_ADD: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  res.dest_value = sum[7:0];
                  res.flag_valid = 1'b1;
                  res.flag_value = sum[8];
               end
               ALU_SUB: begin
                  res.dest_value = vx - vy;
                  res.flag_valid = 1'b1;
                  res.flag_value = (vx >= vy);
               end
               ALU_SHR: begin
                  res.dest_value = vy >> 1;
                  res.flag_valid = 1'b1;
                  res.flag_value = vy[0];
               end
               ALU_SUBN: begin
                  res.dest_value = vy - vx;
                  res.flag_valid = 1'b1;
                  res.flag_value = (vy >= vx);
               end
               ALU_SHL: begin
                  res.dest_value = {vy[6:0], 1'b0};
                  res.flag_valid = 1'b1;
                  res.flag_value = vy[7];
               end
               default: begin
                  res.dest_valid = 1'b0;
                  res.status     = 1'b1;
               end
            endcase
         end
         CLS_SNEV: begin
            if (n == 4'h0) skip = (vx != vy);
            else res.status = 1'b1;
         end
         CLS_LDI:  index_shadow = {4'h0, nnn};
         CLS_JPV0: pc = nnn + {4'h0, vreg_file[V0_NUM]};
         CLS_RND: begin
            res.dest_valid = 1'b1;
            res.dest_value = rnd & nn;
         end
         CLS_MISC: begin
            case (nn)
               FX_GET_DT: begin
                  res.dest_valid = 1'b1;
                  res.dest_value = delay_shadow;
               end
               FX_SET_DT: delay_shadow = vx;
               FX_SET_ST: sound_shadow = vx;
               FX_ADD_I:  index_shadow = index_shadow + {8'h00, vx};
               default:   res.status = 1'b1;
            endcase
         end
         default: res.status = 1'b1;
      endcase

      if (skip) begin
         pc = pc + 12'd2;
         skip_tally++;
      end
      if (res.dest_valid) begin
         res.dest_reg = x;
         vreg_file[x] = res.dest_value;
      end
      // VF flag lands after the destination write
      if (res.flag_valid) begin
         vreg_file[VF_NUM] = {7'h00, res.flag_value};
         flag_tally++;
      end
      if (res.status) unhandled_tally++;
      pc_shadow       = pc;
      res.next_pc     = pc;
      res.index_value = index_shadow;
      res.delay_value = delay_shadow;
      res.sound_value = sound_shadow;
   endtask

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatch_tally++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      exec_result_type want;
      exec_result_type predicted;
      if (reset) begin
         for (int i = 0; i < NUM_V; i++) vreg_file[i] = '0;
         index_shadow = '0;
         pc_shadow    = PROGRAM_START[PC_W-1:0];
         delay_shadow = '0;
         sound_shadow = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_tally++;
               $display("%0t: rsp beat mismatch, expected no beat, actual next_pc 0x%0h",
                        $time, rsp_next_pc);
            end else begin
               want = expected_results.pop_front();
               check_field("next_pc",      16'(want.next_pc),      16'(rsp_next_pc));
               check_field("index_value",  want.index_value,       rsp_index_value);
               check_field("dest_valid",   16'(want.dest_valid),   16'(rsp_dest_valid));
               check_field("dest_reg",     16'(want.dest_reg),     16'(rsp_dest_reg));
               check_field("dest_value",   16'(want.dest_value),   16'(rsp_dest_value));
               check_field("flag_valid",   16'(want.flag_valid),   16'(rsp_flag_valid));
               check_field("flag_value",   16'(want.flag_value),   16'(rsp_flag_value));
               check_field("clear_screen", 16'(want.clear_screen), 16'(rsp_clear_screen));
               check_field("delay_value",  16'(want.delay_value),  16'(rsp_delay_value));
               check_field("sound_value",  16'(want.sound_value),  16'(rsp_sound_value));
               check_field("status",       16'(want.status),       16'(rsp_status));
               checked_tally++;
            end
         end
         if (req_valid && req_ready) begin
            execute_instr(req_instr_word, req_random_byte, predicted);
            expected_results.push_back(predicted);
         end
      end
      fail_count      <= mismatch_tally;
      pending_count   <= expected_results.size();
      checked_count   <= checked_tally;
      unhandled_count <= unhandled_tally;
      skip_count      <= skip_tally;
      flag_count      <= flag_tally;
   end

endmodule

@@ tb/sv/tb_chip8_instruction_execute.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute
// Drives directed and random CHIP-8 instructions into the executor with random
// gaps and back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_execute
   import chip8ie_pkg::*;
();

   // Left-out and invalid codes that the block must report as unhandled
   localparam logic [15:0] OP_RET      = 16'h00EE;
   localparam logic [7:0]  KEY_SKP     = 8'h9E;
   localparam logic [7:0]  KEY_SKNP    = 8'hA1;
   localparam logic [7:0]  FX_WAIT_KEY = 8'h0A;
   localparam logic [7:0]  FX_FONT     = 8'h29;
   localparam logic [7:0]  FX_BCD      = 8'h33;
   localparam logic [7:0]  FX_STORE    = 8'h55;
   localparam logic [7:0]  FX_LOAD     = 8'h65;
   localparam logic [3:0]  ALU_BAD     = 4'h8;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic [15:0] req_instr_word  = '0;
   logic [7:0]  req_random_byte = '0;
   logic        rsp_ready       = 1'b0;

   logic        req_ready;
   logic        rsp_valid;
   logic [11:0] rsp_next_pc;
   logic [15:0] rsp_index_value;
   logic        rsp_dest_valid;
   logic [3:0]  rsp_dest_reg;
   logic [7:0]  rsp_dest_value;
   logic        rsp_flag_valid;
   logic        rsp_flag_value;
   logic        rsp_clear_screen;
   logic [7:0]  rsp_delay_value;
   logic [7:0]  rsp_sound_value;
   logic        rsp_status;

   int fail_count, pending_count, checked_count;
   int unhandled_count, skip_count, flag_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   chip8_instruction_execute #(.PROGRAM_START(512)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instr_word   (req_instr_word),
      .req_random_byte  (req_random_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_index_value  (rsp_index_value),
      .rsp_dest_valid   (rsp_dest_valid),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_dest_value   (rsp_dest_value),
      .rsp_flag_valid   (rsp_flag_valid),
      .rsp_flag_value   (rsp_flag_value),
      .rsp_clear_screen (rsp_clear_screen),
      .rsp_delay_value  (rsp_delay_value),
      .rsp_sound_value  (rsp_sound_value),
      .rsp_status       (rsp_status)
   );

   chip8_exec_checker #(.PROGRAM_START(512)) exec_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instr_word   (req_instr_word),
      .req_random_byte  (req_random_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_index_value  (rsp_index_value),
      .rsp_dest_valid   (rsp_dest_valid),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_dest_value   (rsp_dest_value),
      .rsp_flag_valid   (rsp_flag_valid),
      .rsp_flag_value   (rsp_flag_value),
      .rsp_clear_screen (rsp_clear_screen),
      .rsp_delay_value  (rsp_delay_value),
      .rsp_sound_value  (rsp_sound_value),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .unhandled_count  (unhandled_count),
      .skip_count       (skip_count),
      .flag_count       (flag_count)
   );

   // Offer one instruction beat, hold it until accepted, then at random idle a while.
   task automatic offer_instr(input logic [15:0] word, input logic [7:0] rnd);
      int gap;
      int pick;
      req_valid       <= 1'b1;
      req_instr_word  <= word;
      req_random_byte <= rnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pick = $urandom_range(0, 99);
      if (pick < 65) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted result has been seen.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      logic [15:0] word;
      logic [11:0] addr;
      logic [7:0]  nn;
      logic [3:0]  x, y, fn;
      int          pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: clear and return, ALU flags incl. VF as destination
      offer_instr(OP_CLS, 8'h00);
      offer_instr(OP_RET, 8'hFF);
      offer_instr({CLS_LD, V0_NUM, 8'hFF}, 8'h00);
      offer_instr({CLS_LD, 4'h1, 8'h01}, 8'hFF);
      offer_instr({CLS_ALU, V0_NUM, 4'h1, ALU_ADD}, 8'h00);
      offer_instr({CLS_ALU, V0_NUM, 4'h1, ALU_SUB}, 8'h00);
      offer_instr({CLS_ALU, 4'h1, V0_NUM, ALU_SUBN}, 8'h00);
      offer_instr({CLS_ALU, VF_NUM, V0_NUM, ALU_SHR}, 8'h00);
      offer_instr({CLS_ALU, 4'h2, V0_NUM, ALU_SHL}, 8'h00);
      offer_instr({CLS_ALU, VF_NUM, 4'h1, ALU_ADD}, 8'h00);
      offer_instr({CLS_ALU, V0_NUM, 4'h1, ALU_BAD}, 8'h00);
      // skips, then a jump to the top of memory so the skip wraps the PC
      offer_instr({CLS_SE, V0_NUM, 8'hFF}, 8'h00);
      offer_instr({CLS_SNE, V0_NUM, 8'hFF}, 8'h00);
      offer_instr({CLS_SEV, V0_NUM, 4'h1, 4'h0}, 8'h00);
      offer_instr({CLS_SNEV, V0_NUM, 4'h1, 4'h0}, 8'h00);
      offer_instr({CLS_SEV, V0_NUM, 4'h1, 4'h1}, 8'h00);
      offer_instr({CLS_JP, 12'hFFC}, 8'h00);
      offer_instr({CLS_SE, V0_NUM, 8'hFF}, 8'h00);
      offer_instr({CLS_JPV0, 12'hFFF}, 8'h00);
      offer_instr({CLS_LDI, 12'hFFF}, 8'h00);
      offer_instr({CLS_MISC, V0_NUM, FX_ADD_I}, 8'h00);
      offer_instr({CLS_MISC, V0_NUM, FX_SET_DT}, 8'h00);
      offer_instr({CLS_MISC, 4'h1, FX_SET_ST}, 8'h00);
      offer_instr({CLS_MISC, 4'h3, FX_GET_DT}, 8'h00);
      offer_instr({CLS_RND, V0_NUM, 8'hFF}, 8'hA5);
      offer_instr({CLS_RND, VF_NUM, 8'h0F}, 8'hFF);
      offer_instr({CLS_DRW, 12'h123}, 8'h00);
      offer_instr({CLS_KEY, V0_NUM, KEY_SKP}, 8'h00);
      offer_instr({CLS_MISC, V0_NUM, FX_BCD}, 8'h00);
      drain_results();

      for (int k = 0; k < 1060; k++) begin
         if (k == 400) drain_results();
         if (k == 600) begin
            // walk I past 16 bits with repeated FX1E of 0xFF
            offer_instr({CLS_LD, 4'hE, 8'hFF}, 8'($urandom_range(0, 255)));
            offer_instr({CLS_LDI, 12'hFFF}, 8'($urandom_range(0, 255)));
            repeat (260)
               offer_instr({CLS_MISC, 4'hE, FX_ADD_I}, 8'($urandom_range(0, 255)));
         end
         x    = 4'($urandom_range(0, 15));
         y    = 4'($urandom_range(0, 15));
         addr = 12'($urandom_range(0, 12'hFFF));
         // favor a small pool of bytes so compares and skips hit often
         case ($urandom_range(0, 11))
            0:       nn = 8'h00;
            1:       nn = 8'h01;
            2:       nn = 8'h7F;
            3:       nn = 8'h80;
            4:       nn = 8'hFE;
            5:       nn = 8'hFF;
            default: nn = 8'($urandom_range(0, 255));
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            word = 16'($urandom_range(0, 16'hFFFF));
         end else if (pick < 25) begin
            word = {CLS_LD, x, nn};
         end else if (pick < 50) begin
            case ($urandom_range(0, 9))
               0:       fn = ALU_MOV;
               1:       fn = ALU_OR;
               2:       fn = ALU_AND;
               3:       fn = ALU_XOR;
               4:       fn = ALU_ADD;
               5:       fn = ALU_SUB;
               6:       fn = ALU_SHR;
               7:       fn = ALU_SUBN;
               8:       fn = ALU_SHL;
               default: fn = 4'($urandom_range(0, 15));
            endcase
            word = {CLS_ALU, x, y, fn};
         end else if (pick < 58) begin
            word = {CLS_ADD, x, nn};
         end else if (pick < 70) begin
            case ($urandom_range(0, 3))
               0:       word = {CLS_SE, x, nn};
               1:       word = {CLS_SNE, x, nn};
               2:       word = {CLS_SEV, x, y, 4'h0};
               default: word = {CLS_SNEV, x, y, 4'h0};
            endcase
         end else if (pick < 76) begin
            case ($urandom_range(0, 2))
               0:       word = {CLS_JP, addr};
               1:       word = {CLS_CALL, addr};
               default: word = {CLS_JPV0, addr};
            endcase
         end else if (pick < 82) begin
            if ($urandom_range(0, 1)) word = {CLS_LDI, addr};
            else word = {CLS_MISC, x, FX_ADD_I};
         end else if (pick < 87) begin
            word = {CLS_RND, x, nn};
         end else if (pick < 94) begin
            case ($urandom_range(0, 2))
               0:       word = {CLS_MISC, x, FX_GET_DT};
               1:       word = {CLS_MISC, x, FX_SET_DT};
               default: word = {CLS_MISC, x, FX_SET_ST};
            endcase
         end else begin
            case ($urandom_range(0, 8))
               0:       word = OP_CLS;
               1:       word = OP_RET;
               2:       word = {CLS_DRW, addr};
               3:       word = {CLS_KEY, x, KEY_SKP};
               4:       word = {CLS_KEY, x, KEY_SKNP};
               5:       word = {CLS_MISC, x, FX_WAIT_KEY};
               6:       word = {CLS_MISC, x, FX_FONT};
               7:       word = {CLS_MISC, x, FX_BCD};
               default: word = {CLS_MISC, x, ($urandom_range(0, 1) ? FX_STORE : FX_LOAD)};
            endcase
         end
         offer_instr(word, 8'($urandom_range(0, 255)));
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d instruction results: %0d unhandled, %0d taken skips,",
               checked_count, unhandled_count, skip_count);
      $display("%0d VF flag writes, under random gaps and long result back-pressure.",
               flag_count);
      if (fail_count == 0) begin
         $display("tb_chip8_instruction_execute passed");
      end else begin
         $display("tb_chip8_instruction_execute failed");
      end
      $finish;
   end

   // Result side: random ready with two long holdoffs to fill the pipeline.
   initial begin
      logic early_hold_done;
      logic late_hold_done;
      int   pick;
      int   run;
      early_hold_done = 1'b0;
      late_hold_done  = 1'b0;
      @(posedge clock);
      forever begin
         if ((!early_hold_done && checked_count >= 300) ||
             (!late_hold_done && checked_count >= 900)) begin
            if (!early_hold_done) early_hold_done = 1'b1;
            else late_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (120) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rsp_ready <= 1'b1;
               run = $urandom_range(1, 20);
            end else if (pick < 90) begin
               rsp_ready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               run = $urandom_range(10, 40);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_chip8_instruction_execute failed");
      $finish;
   end

endmodule
